// ===== hw/rtl/seed_block_cipher_core_defines.svh =====
// Assertion macros shared by the SEED core checker.
`ifndef SEED_BLOCK_CIPHER_CORE_DEFINES_SVH
`define SEED_BLOCK_CIPHER_CORE_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next, ignored in reset.
`define SBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbc check failed");

// Same, but also checked while reset is held.
`define SBC_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sbc reset check failed");

`endif

// ===== hw/rtl/sbc_pkg.sv =====
// Shared types, constants and the G function of the SEED core.
package sbc_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int NUM_ROUNDS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
  } rkey_pair_t;

  typedef struct packed {
    logic shift;
    logic backward;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HOLD
  } sbc_state_t;

  // S-box bytes, entry 0 in the top byte
  localparam logic [2047:0] SBOX1_BITS = {
    128'ha985d6d3541dac255d43181e51fcca63, 128'h2844209de0e2c817a58f037bbb13d2ee,
    128'h708c3fa832ddf674ec950b575c5bbd01, 128'h241c739810ccf2d92ce772839bd186c9,
    128'h6050a3eb0db69e4fb75ac678a612afd5, 128'h61c3b441527d8d081f9900190453f7e1,
    128'hfd762f27b08b0eaba26e934d697c090a, 128'hbfeff3c58714fe64de2e4b1a06216b66,
    128'h02f5928a0cb37ed07a4796e52680addf, 128'ha13037ae36152238f4a7454c81e98497,
    128'h35cbce3c7111c78975fbdaf8945982c4, 128'hff493967c0cfd7b80f8e4223916cdba4,
    128'h34f148c26f3d2d40be3ebcc1aaba4e55, 128'h3bdc687f9cd84a5677a0ed46b52b65fa,
    128'he3b9b19f5ef9e6b231ea6d5fe4f0cd88, 128'h163a58d462290733e81b0579906a2a9a
  };

  localparam logic [2047:0] SBOX2_BITS = {
    128'h38e82da6cfdeb3b8af6055c7446f6b5b, 128'hc36233b529a0e2a7d39111061cbc364b,
    128'hef886ca817c416f4c245e1d63f3d8e98, 128'h284ef63ea5f90ddfd82b667a272ff172,
    128'h42d441c07367ac8bf7ad801fca2caa34, 128'hd20beee95d9418f857ae08c513cd86b9,
    128'hff7dc131f58a6ab1d120d70222046871, 128'h07db9d9961bee659dd5190dc9aa3abd0,
    128'h810f471ae3ec8dbf967b5ca2a163234d, 128'hc89e9c3a0c2eba6e9f5af292f34978cc,
    128'h15fb70757f351003646dc674d5b4ea09, 128'h7619fe4012e0bd05fa01f02a5ea95643,
    128'h8514899bb0e5487997fc1e82218c1b5f, 128'h7754b21d254f0046ed5852eb7edac9fd,
    128'h3095653cb6e4bb7c0e50392632846993, 128'h37e724a4cb530a87d94c838fce3b4ab7
  };

  localparam logic [31:0] ROUND_CONST [NUM_ROUNDS] = '{
    32'h9E3779B9, 32'h3C6EF373, 32'h78DDE6E6, 32'hF1BBCDCC,
    32'hE3779B99, 32'hC6EF3733, 32'h8DDE6E67, 32'h1BBCDCCF,
    32'h3779B99E, 32'h6EF3733C, 32'hDDE6E678, 32'hBBCDCCF1,
    32'h779B99E3, 32'hEF3733C6, 32'hDE6E678D, 32'hBCDCCF1B
  };

  function automatic logic [7:0] sbox1(input logic [7:0] a);
    return SBOX1_BITS[{~a, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] sbox2(input logic [7:0] a);
    return SBOX2_BITS[{~a, 3'b000} +: 8];
  endfunction

  // G: four byte lookups, then masked XOR mixing
  function automatic logic [31:0] seed_g(input logic [31:0] x);
    logic [7:0] y0, y1, y2, y3, z0, z1, z2, z3;
    y0 = sbox1(x[7:0]);
    y1 = sbox2(x[15:8]);
    y2 = sbox1(x[23:16]);
    y3 = sbox2(x[31:24]);
    z0 = (y0 & 8'hfc) ^ (y1 & 8'hf3) ^ (y2 & 8'hcf) ^ (y3 & 8'h3f);
    z1 = (y0 & 8'hf3) ^ (y1 & 8'hcf) ^ (y2 & 8'h3f) ^ (y3 & 8'hfc);
    z2 = (y0 & 8'hcf) ^ (y1 & 8'h3f) ^ (y2 & 8'hfc) ^ (y3 & 8'hf3);
    z3 = (y0 & 8'h3f) ^ (y1 & 8'hfc) ^ (y2 & 8'hf3) ^ (y3 & 8'hcf);
    return {z3, z2, z1, z0};
  endfunction

endpackage

// ===== hw/rtl/sbc_in_if.sv =====
// Input channel: one block and its direction bit.
interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic        decrypt;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, decrypt, block_high, block_low, input ready);
  modport sink (input valid, decrypt, block_high, block_low, output ready);
endinterface

// ===== hw/rtl/sbc_out_if.sv =====
// Result channel: one processed block.
interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== hw/rtl/sbc_cfg_if.sv =====
// Configuration write channel: register index and data.
interface sbc_cfg_if import sbc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sbc_kcell.sv =====
// One round-key cell of the key ring.
module sbc_kcell import sbc_pkg::*; (
  input  logic       clk,
  input  ring_ctl_t  ctl,
  input  rkey_pair_t from_next,
  input  rkey_pair_t from_prev,
  output rkey_pair_t pair
);

  rkey_pair_t pair_r;
  rkey_pair_t pair_nxt;

  always_comb begin
    pair_nxt = pair_r;
    if (ctl.shift) begin
      pair_nxt = ctl.backward ? from_prev : from_next;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

  assign pair = pair_r;

endmodule

// ===== hw/rtl/sbc_kexp.sv =====
// Key expansion: one round-key pair per cycle into the ring.
module sbc_kexp import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  output logic        busy,
  output rkey_pair_t  pair
);

  logic [63:0] ab_r, ab_nxt;
  logic [63:0] cd_r, cd_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] rc;

  assign rc      = ROUND_CONST[cnt_r];
  assign pair.k0 = seed_g(ab_r[63:32] + cd_r[63:32] - rc);
  assign pair.k1 = seed_g(ab_r[31:0] - cd_r[31:0] + rc);
  assign busy    = busy_r;

  always_comb begin
    ab_nxt   = ab_r;
    cd_nxt   = cd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      ab_nxt   = key_high;
      cd_nxt   = key_low;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // even steps rotate AB right, odd steps rotate CD left
      if (!cnt_r[0]) begin
        ab_nxt = {ab_r[7:0], ab_r[63:8]};
      end else begin
        cd_nxt = {cd_r[55:0], cd_r[63:56]};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(NUM_ROUNDS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // reset runs the schedule of the all-zero key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ab_r   <= '0;
      cd_r   <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      ab_r   <= ab_nxt;
      cd_r   <= cd_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hw/rtl/seed_block_cipher_core.sv =====
// Top level of the SEED-128 block cipher core.
// SEED-128 encrypt/decrypt core. Each input item is a 128-bit block
// (block_high = bytes 0..7, big-endian) plus a decrypt bit; each result item
// is the 128-bit output block. One Feistel round runs per clock on a single
// round unit; the last round writes the output register directly if it is
// free, else the block waits in the round registers until it is. A new block
// can be accepted in the cycle after the previous one leaves the round unit,
// so the core takes one block at a time. The 16 round-key pairs live in a
// ring of 16 cells that rotates one step per round: forward for encryption,
// backward for decryption, and it is back in place after the last round.
// Writing key register 0 (high) or 1 (low) re-expands the schedule from both
// halves, one pair per cycle, so no block is accepted in the write cycle or
// while the expansion runs; the same expansion of the all-zero key runs right
// after reset. Key writes are held off while a block is in the rounds. Other
// register indexes are accepted and ignored. The finished block sits in an
// output register, so the core can take the next block while it waits.
module seed_block_cipher_core import sbc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  sbc_in_if.sink   in_chan,
  sbc_out_if.source out_chan,
  sbc_cfg_if.sink  cfg_chan
);

  // config / key registers
  logic [63:0] key_high_r, key_high_nxt;
  logic [63:0] key_low_r, key_low_nxt;
  logic        cfg_wr;
  logic        kexp_start;
  logic        kexp_busy;
  rkey_pair_t  kexp_pair;

  // datapath and control
  sbc_state_t  state_r, state_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic        dec_r, dec_nxt;
  logic [63:0] l_r, l_nxt;
  logic [63:0] rr_r, rr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_high_r, out_high_nxt;
  logic [63:0] out_low_r, out_low_nxt;
  logic        in_ready;
  logic        in_acc;
  logic        out_free;

  // key ring
  ring_ctl_t   ring_ctl;
  rkey_pair_t  cell_q [NUM_ROUNDS];
  rkey_pair_t  rk;

  // round unit
  logic [31:0] c0, d0, d1, c1, d2, c2;
  logic [63:0] new_r;

  // key writes wait while the ring feeds the rounds
  assign cfg_chan.ready = (state_r != ST_ROUND);
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;
  assign kexp_start     = cfg_wr &&
                          (cfg_chan.index == REG_KEY_HIGH || cfg_chan.index == REG_KEY_LOW);
  assign key_high_nxt   = (cfg_wr && cfg_chan.index == REG_KEY_HIGH) ? cfg_chan.data
                                                                     : key_high_r;
  assign key_low_nxt    = (cfg_wr && cfg_chan.index == REG_KEY_LOW) ? cfg_chan.data
                                                                    : key_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
    end
  end

  sbc_kexp u_kexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kexp_start),
    .key_high (key_high_nxt),
    .key_low  (key_low_nxt),
    .busy     (kexp_busy),
    .pair     (kexp_pair)
  );

  // ring shifts during expansion (forward, fed at the tail) and each round
  assign ring_ctl.shift    = kexp_busy || (state_r == ST_ROUND);
  assign ring_ctl.backward = !kexp_busy && dec_r;

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_ring
    rkey_pair_t nxt_in;
    if (i == NUM_ROUNDS - 1) begin : g_tail
      assign nxt_in = kexp_busy ? kexp_pair : cell_q[0];
    end else begin : g_body
      assign nxt_in = cell_q[i + 1];
    end
    sbc_kcell u_cell (
      .clk       (clk),
      .ctl       (ring_ctl),
      .from_next (nxt_in),
      .from_prev (cell_q[(i + NUM_ROUNDS - 1) % NUM_ROUNDS]),
      .pair      (cell_q[i])
    );
  end

  // encryption takes keys from the head, decryption from the tail
  assign rk = dec_r ? cell_q[NUM_ROUNDS - 1] : cell_q[0];

  // one Feistel round: F on the right half, XOR into the left, swap
  assign c0    = rr_r[63:32] ^ rk.k0;
  assign d0    = rr_r[31:0] ^ rk.k1;
  assign d1    = seed_g(d0 ^ c0);
  assign c1    = seed_g(c0 + d1);
  assign d2    = seed_g(d1 + c1);
  assign c2    = c1 + d2;
  assign new_r = {l_r[63:32] ^ c2, l_r[31:0] ^ d2};

  // a pending key write takes precedence over a block
  assign in_ready      = (state_r == ST_IDLE) && !kexp_busy && !cfg_chan.valid;
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    dec_nxt       = dec_r;
    l_nxt         = l_r;
    rr_nxt        = rr_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_high_nxt  = out_high_r;
    out_low_nxt   = out_low_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          l_nxt     = in_chan.block_high;
          rr_nxt    = in_chan.block_low;
          dec_nxt   = in_chan.decrypt;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        l_nxt   = rr_r;
        rr_nxt  = new_r;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'(NUM_ROUNDS - 1)) begin
          // halves leave swapped
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_high_nxt  = new_r;
            out_low_nxt   = rr_r;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_high_nxt  = rr_r;
          out_low_nxt   = l_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    rr_r       <= rr_nxt;
    out_high_r <= out_high_nxt;
    out_low_r  <= out_low_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_high = out_high_r;
  assign out_chan.result_low  = out_low_r;

endmodule

// ===== hw/rtl/sbc_chk.sv =====
// Port-level checker for the SEED core, bound to the top level.
`include "seed_block_cipher_core_defines.svh"

module sbc_chk import sbc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [63:0]          out_high,
  input logic [63:0]          out_low,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // a stalled result holds its value
  `SBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_high) && $stable(out_low))
  // one block at a time in the round unit
  `SBC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a key write starts expansion, blocking input
  `SBC_ASSERT_NEXT(a_busy_after_key, cfg_valid && cfg_ready && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW), !in_ready)
  // reset empties the output register and runs expansion
  `SBC_ASSERT_NEXT_RST(a_reset_clear, !rst_n, !out_valid && !in_ready)

endmodule

bind seed_block_cipher_core sbc_chk u_sbc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_high  (out_chan.result_high),
  .out_low   (out_chan.result_low),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready),
  .cfg_index (cfg_chan.index)
);
